>>> src/kcar_pkg.sv
package kcar_pkg;

	localparam int KEY_W = 4;
	localparam int WORD_W = 16;
	localparam int TIME_W = 32;
	localparam int CFG_W = 16;
	localparam int MAP_SIZE = 12;
	localparam int DEFAULT_NUM_KEYS = 12;

	localparam logic [CFG_W-1:0] INITIAL_DELAY_RESET = 16'd500;
	localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RESET = 16'd175;

	typedef enum logic {
		REG_INITIAL_DELAY = 1'b0,
		REG_REPEAT_INTERVAL = 1'b1
	} reg_index_t;

	// Key map in map order: bit mask and whether the key sits in the shutter word.
	localparam logic [WORD_W-1:0] KEY_MASK [MAP_SIZE] = '{
		16'h4000, 16'h0400, 16'h0100, 16'h0200,
		16'h8000, 16'h0300, 16'h0100, 16'h0010,
		16'h0020, 16'h2000, 16'h1000, 16'h0800
	};
	localparam logic [MAP_SIZE-1:0] KEY_ON_SHUTTER = 12'b0000_0110_0000;

	typedef struct packed {
		logic [KEY_W-1:0] pressed;
		logic [KEY_W-1:0] clicked;
	} scan_t;

endpackage

>>> src/kcar_scan.sv
module kcar_scan #(
	parameter int NUM_KEYS = kcar_pkg::DEFAULT_NUM_KEYS
) (
	input  logic [kcar_pkg::WORD_W-1:0] main_word,
	input  logic [kcar_pkg::WORD_W-1:0] shutter_word,
	input  logic [kcar_pkg::WORD_W-1:0] prev_main_word,
	input  logic [kcar_pkg::WORD_W-1:0] prev_shutter_word,
	output logic [NUM_KEYS-1:0]         key_pressed,
	output kcar_pkg::scan_t             scan
);

	logic [NUM_KEYS-1:0] was_down;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		if (k < kcar_pkg::MAP_SIZE) begin : g_mapped
			logic [kcar_pkg::WORD_W-1:0] now_w;
			logic [kcar_pkg::WORD_W-1:0] prev_w;
			assign now_w = kcar_pkg::KEY_ON_SHUTTER[k] ? shutter_word : main_word;
			assign prev_w = kcar_pkg::KEY_ON_SHUTTER[k] ? prev_shutter_word : prev_main_word;
			assign key_pressed[k] = (now_w & kcar_pkg::KEY_MASK[k]) == '0;
			assign was_down[k] = (prev_w & kcar_pkg::KEY_MASK[k]) == '0;
		end else begin : g_unmapped
			assign key_pressed[k] = 1'b0;
			assign was_down[k] = 1'b0;
		end
	end

	// Walking down from the last key leaves the first key in map order.
	always_comb begin
		scan = '0;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (key_pressed[k]) begin
				scan.pressed = kcar_pkg::KEY_W'(k + 1);
			end
			if (key_pressed[k] && !was_down[k]) begin
				scan.clicked = kcar_pkg::KEY_W'(k + 1);
			end
		end
	end

endmodule

>>> src/keypad_click_and_autorepeat.sv
// Keypad click detector with typematic autorepeat.
// Each request on the s_ channel is one scan: s_tdata holds the active-low
// main key word, the shutter key word and a millisecond timestamp, and
// s_tuser asks to forget the remembered repeat key before the scan.
// Each scan yields exactly one request on the m_ channel carrying the first
// pressed key, the first newly clicked key and the click or autorepeat key,
// each 0 when there is none.
// The cfg channel writes the initial delay and the repeat interval; it is
// always ready and should only be used while no scan is in flight.
// A scan is registered, evaluated in one pass against the previous scan and
// the repeat timer, and its result is registered: the result is offered on
// the m_ channel from the result register once the scan advances out of the
// input register, and one scan is accepted every cycle unless the receiver stalls.
// When the receiver stalls, the result register holds, one more scan waits
// in the input register, and s_tready drops until the result is taken.
// Reset empties both registers, restores the default delay and interval,
// and treats the previous scan as having no key pressed.
module keypad_click_and_autorepeat #(
	parameter int NUM_KEYS = kcar_pkg::DEFAULT_NUM_KEYS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // main_keys_word, shutter_keys_word, now_ms
	input  logic        s_tuser,  // clear_repeat
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // pressed_key, clicked_key, repeat_key, zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int KW = kcar_pkg::KEY_W;
	localparam int WW = kcar_pkg::WORD_W;
	localparam int TW = kcar_pkg::TIME_W;

	logic          valid_s1;
	logic [WW-1:0] main_s1;
	logic [WW-1:0] shutter_s1;
	logic [TW-1:0] now_s1;
	logic          clear_s1;

	logic [WW-1:0] prev_main_q;
	logic [WW-1:0] prev_shutter_q;
	logic [KW-1:0] held_q;
	logic [TW-1:0] last_event_q;
	logic          repeated_q;
	logic [kcar_pkg::CFG_W-1:0] initial_delay_q;
	logic [kcar_pkg::CFG_W-1:0] repeat_interval_q;

	logic          out_valid_q;
	logic [KW-1:0] pressed_q;
	logic [KW-1:0] clicked_q;
	logic [KW-1:0] repeat_q;

	logic                advance;
	logic [NUM_KEYS-1:0] key_pressed;
	kcar_pkg::scan_t     scan;
	logic [KW-1:0]       held_eff;
	logic                held_down;
	logic [TW-1:0]       elapsed;
	logic [kcar_pkg::CFG_W-1:0] limit;
	logic                timer_fire;
	logic [KW-1:0]       repeat_key;
	logic [KW-1:0]       held_next;
	logic                repeated_next;
	logic                stamp;

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	kcar_scan #(
		.NUM_KEYS(NUM_KEYS)
	) u_scan (
		.main_word        (main_s1),
		.shutter_word     (shutter_s1),
		.prev_main_word   (prev_main_q),
		.prev_shutter_word(prev_shutter_q),
		.key_pressed      (key_pressed),
		.scan             (scan)
	);

	always_comb begin
		held_eff = clear_s1 ? '0 : held_q;
		held_down = 1'b0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (held_eff == KW'(k + 1) && key_pressed[k]) begin
				held_down = 1'b1;
			end
		end
		elapsed = now_s1 - last_event_q;
		limit = repeated_q ? repeat_interval_q : initial_delay_q;
		timer_fire = elapsed > TW'(limit);

		repeat_key = '0;
		held_next = held_eff;
		repeated_next = repeated_q;
		stamp = 1'b0;
		priority if (scan.clicked != '0) begin
			held_next = scan.clicked;
			repeated_next = 1'b0;
			stamp = 1'b1;
			repeat_key = scan.clicked;
		end else if (held_down) begin
			if (timer_fire) begin
				repeated_next = 1'b1;
				stamp = 1'b1;
				repeat_key = held_eff;
			end
		end else begin
			held_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			main_s1 <= '1;
			shutter_s1 <= '1;
			now_s1 <= '0;
			clear_s1 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (s_tvalid && s_tready) begin
				main_s1 <= s_tdata[15:0];
				shutter_s1 <= s_tdata[31:16];
				now_s1 <= s_tdata[63:32];
				clear_s1 <= s_tuser;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_main_q <= '1;
			prev_shutter_q <= '1;
			held_q <= '0;
			last_event_q <= '0;
			repeated_q <= 1'b0;
		end else if (advance) begin
			prev_main_q <= main_s1;
			prev_shutter_q <= shutter_s1;
			held_q <= held_next;
			repeated_q <= repeated_next;
			if (stamp) begin
				last_event_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_delay_q <= kcar_pkg::INITIAL_DELAY_RESET;
			repeat_interval_q <= kcar_pkg::REPEAT_INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (kcar_pkg::reg_index_t'(cfg_index))
				kcar_pkg::REG_INITIAL_DELAY: initial_delay_q <= cfg_data;
				kcar_pkg::REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pressed_q <= '0;
			clicked_q <= '0;
			repeat_q <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				pressed_q <= scan.pressed;
				clicked_q <= scan.clicked;
				repeat_q <= repeat_key;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'b0000, repeat_q, clicked_q, pressed_q};

endmodule
